/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Fixed field widths of the command and result channels
  localparam int VALUE_W   = 32;
  localparam int IN_RANK_W = 16;
  localparam int COUNT_W   = 5;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } spq_ctrl_t;

endpackage

/* hw/rtl/spq_ifs.sv */
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface spq_cmd_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [VALUE_W-1:0] item_value;
  logic [IN_RANK_W-1:0]      item_rank;

  modport source (output valid, output command, output item_value, output item_rank,
                  input ready);
  modport sink   (input valid, input command, input item_value, input item_rank,
                  output ready);
endinterface

interface spq_res_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] head_value;
  logic [IN_RANK_W-1:0]      head_rank;
  logic                      queue_empty;
  logic [COUNT_W-1:0]        entry_count;
  logic                      overflow;

  modport source (output valid, output head_value, output head_rank,
                  output queue_empty, output entry_count, output overflow,
                  input ready);
  modport sink   (input valid, input head_value, input head_rank,
                  input queue_empty, input entry_count, input overflow,
                  output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// One slot of the sorted row: compare against the new rank, then keep, load or shift.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
  parameter int RANK_BITS = 16
) (
  input  logic                      clk,
  input  spq_ctrl_t                 ctrl,
  input  logic signed [VALUE_W-1:0] new_value,
  input  logic [RANK_BITS-1:0]      new_rank,
  input  logic                      occupied,
  input  logic                      left_keep,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic [RANK_BITS-1:0]      left_rank,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic [RANK_BITS-1:0]      right_rank,
  output logic                      keep,
  output logic signed [VALUE_W-1:0] value_r,
  output logic [RANK_BITS-1:0]      rank_r,
  output logic signed [VALUE_W-1:0] value_nxt,
  output logic [RANK_BITS-1:0]      rank_nxt
);

  // Equal ranks stay ahead of the newcomer, so arrival order is kept
  assign keep = occupied && (rank_r >= new_rank);

  always_comb begin
    value_nxt = value_r;
    rank_nxt  = rank_r;
    if (ctrl.do_insert && !keep) begin
      if (left_keep) begin
        value_nxt = new_value;
        rank_nxt  = new_rank;
      end else begin
        value_nxt = left_value;
        rank_nxt  = left_rank;
      end
    end else if (ctrl.do_remove) begin
      value_nxt = right_value;
      rank_nxt  = right_rank;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    rank_r  <= rank_nxt;
  end

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Sorted max-priority queue built from a row of compare-and-shift cells.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      command, item_value, item_rank
//   out_ch   out  valid / ready      head_value, head_rank, queue_empty,
//                                    entry_count, overflow
//
// One item per cycle while out_ch drains: every cell compares and shifts in the
// same cycle, and the result lands in the output register at the edge that
// takes the command, so out_ch.valid rises in the cycle after the transfer.
// in_ch.ready is high while the output register is empty or being drained.
// Synchronous active-low reset clears the fill count and the output valid; slot
// contents are not reset, only slots below the fill count are ever shown.
`timescale 1ns / 1ps

module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY  = 16,
  parameter int RANK_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  spq_cmd_if.sink   in_ch,
  spq_res_if.source out_ch
);

  localparam int FILL_W = $clog2(CAPACITY + 1);

  logic                      in_valid;
  logic                      in_ready;
  logic                      out_valid;
  logic                      out_ready;
  logic                      in_fire;
  logic                      full;
  logic [FILL_W-1:0]         fill_r;
  logic [FILL_W-1:0]         fill_nxt;
  logic [RANK_BITS-1:0]      new_rank;
  spq_ctrl_t                 ctrl;

  logic                      keep_chain [0:CAPACITY];
  logic                      occ        [0:CAPACITY-1];
  logic signed [VALUE_W-1:0] val_q      [0:CAPACITY-1];
  logic [RANK_BITS-1:0]      rank_q     [0:CAPACITY-1];
  logic signed [VALUE_W-1:0] val_nxt    [0:CAPACITY-1];
  logic [RANK_BITS-1:0]      rank_nxt   [0:CAPACITY-1];

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] head_value_r;
  logic [IN_RANK_W-1:0]      head_rank_r;
  logic                      queue_empty_r;
  logic [COUNT_W-1:0]        entry_count_r;
  logic                      overflow_r;

  assign in_valid  = in_ch.valid;
  assign out_ready = out_ch.ready;
  assign out_valid = out_valid_r;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign full     = (fill_r == FILL_W'(CAPACITY));
  assign new_rank = RANK_BITS'(in_ch.item_rank);

  // Drop an insert when full, ignore a remove when empty
  assign ctrl.do_insert = in_fire && (in_ch.command == CMD_INSERT) && !full;
  assign ctrl.do_remove = in_fire && (in_ch.command == CMD_REMOVE) && (fill_r != '0);

  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.do_insert) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (ctrl.do_remove) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  // The head cell always loads the newcomer when it does not keep its own entry
  assign keep_chain[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv;
    logic [RANK_BITS-1:0]      lr;
    logic signed [VALUE_W-1:0] rv;
    logic [RANK_BITS-1:0]      rr;

    assign occ[i] = (FILL_W'(i) < fill_r);

    if (i == 0) begin : g_left_edge
      assign lv = '0;
      assign lr = '0;
    end else begin : g_left
      assign lv = val_q[i-1];
      assign lr = rank_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_edge
      assign rv = '0;
      assign rr = '0;
    end else begin : g_right
      assign rv = val_q[i+1];
      assign rr = rank_q[i+1];
    end

    spq_cell #(
      .RANK_BITS (RANK_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (in_ch.item_value),
      .new_rank    (new_rank),
      .occupied    (occ[i]),
      .left_keep   (keep_chain[i]),
      .left_value  (lv),
      .left_rank   (lr),
      .right_value (rv),
      .right_rank  (rr),
      .keep        (keep_chain[i+1]),
      .value_r     (val_q[i]),
      .rank_r      (rank_q[i]),
      .value_nxt   (val_nxt[i]),
      .rank_nxt    (rank_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (fill_nxt != '0) begin
        head_value_r <= val_nxt[0];
        head_rank_r  <= IN_RANK_W'(rank_nxt[0]);
      end else begin
        head_value_r <= '0;
        head_rank_r  <= '0;
      end
      queue_empty_r <= (fill_nxt == '0);
      entry_count_r <= COUNT_W'(fill_nxt);
      overflow_r    <= (in_ch.command == CMD_INSERT) && full;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.head_value  = head_value_r;
  assign out_ch.head_rank   = head_rank_r;
  assign out_ch.queue_empty = queue_empty_r;
  assign out_ch.entry_count = entry_count_r;
  assign out_ch.overflow    = overflow_r;

endmodule

/* hw/rtl/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] head_value,
  input logic [IN_RANK_W-1:0]      head_rank,
  input logic                      queue_empty,
  input logic                      overflow
);

  // A result waiting for transfer stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Every accepted command produces a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted command produced no result");

  // An empty queue shows a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && queue_empty |-> (head_value == '0) && (head_rank == '0))
    else $error("empty queue shows a nonzero head");

  // A dropped insert means the queue was full, never empty
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> !queue_empty)
    else $error("overflow reported on an empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .head_value  (head_value_r),
  .head_rank   (head_rank_r),
  .queue_empty (queue_empty_r),
  .overflow    (overflow_r)
);
